// ===== rtl/core/bsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, codes and helpers for the bank-switching mapper core.
// ----------------------------------------------------------------------------
package bsm_pkg;

	// internal PRG RAM size in bytes (1024..8192)
	localparam int WORK_RAM_BYTES = 8192;
	localparam int RAM_AW         = $clog2(WORK_RAM_BYTES);

	// bus operations
	localparam logic [2:0] OP_CPU_READ  = 3'd0;
	localparam logic [2:0] OP_CPU_WRITE = 3'd1;
	localparam logic [2:0] OP_PPU_READ  = 3'd2;
	localparam logic [2:0] OP_PPU_WRITE = 3'd3;
	localparam logic [2:0] OP_A12_EDGE  = 3'd4;

	// result targets
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_RAM  = 2'd1;
	localparam logic [1:0] TGT_PRG  = 2'd2;
	localparam logic [1:0] TGT_CHR  = 2'd3;

	// mirroring codes
	localparam logic [1:0] MIR_VERTICAL = 2'd0;
	localparam logic [1:0] MIR_FOUR     = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W     = 1;
	localparam logic [0:0] CFG_PRG_UNITS = 1'd0;
	localparam logic [0:0] CFG_ALT_NT    = 1'd1;
	localparam int         CFG_DATA_W    = 6;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [18:0] mapped_address;
		logic [7:0]  read_data;
		logic        external_write;
		logic        irq_pulse;
		logic [1:0]  mirroring;
	} out_item_t;

	// banking state seen by the address mapper
	typedef struct packed {
		logic [7:0][7:0] bank_regs;
		logic            prg_swap_mode;
		logic            chr_invert;
		logic [5:0]      prg_units;
	} map_state_t;

	// RAM index of a CPU address in 0x6000-0x7FFF, wrapped to the RAM size
	function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] addr);
		logic [13:0] x;
		x = {1'b0, addr[12:0]};
		for (int i = 0; i < 7; i++) begin
			if (WORK_RAM_BYTES < 8192 && x >= 14'(WORK_RAM_BYTES))
				x = x - 14'(WORK_RAM_BYTES);
		end
		return x[RAM_AW-1:0];
	endfunction

endpackage

// ===== rtl/core/bsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_ram
// PRG work RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsm_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bsm_pkg::RAM_AW-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [bsm_pkg::RAM_AW-1:0] raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [bsm_pkg::WORK_RAM_BYTES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bsm_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_map
// PRG and CHR bank translation from the current banking state.
// ----------------------------------------------------------------------------
module bsm_map (
	input  bsm_pkg::map_state_t st,
	input  logic [15:0]         addr,
	output logic [18:0]         prg_addr,
	output logic [18:0]         chr_addr
);

	logic [4:0]  units_m1;
	logic [5:0]  prg_bank;
	logic [12:0] chr_a;
	logic [17:0] chr_raw;
	logic [7:0]  chr_reg;

	// PRG: 8 KiB windows, last two banks fixed
	always_comb begin
		units_m1 = 5'(st.prg_units - 6'd1);
		case (addr[14:13])
			2'b00:   prg_bank = st.prg_swap_mode ? {units_m1, 1'b0} : st.bank_regs[6][5:0];
			2'b01:   prg_bank = st.bank_regs[7][5:0];
			2'b10:   prg_bank = st.prg_swap_mode ? st.bank_regs[6][5:0] : {units_m1, 1'b0};
			default: prg_bank = {units_m1, 1'b1};
		endcase
		prg_addr = {prg_bank, addr[12:0]};
	end

	// CHR: two 2 KiB and four 1 KiB windows, halves swapped by inversion
	always_comb begin
		chr_a   = addr[12:0] ^ {st.chr_invert, 12'h000};
		chr_reg = st.bank_regs[3'd2 + {1'b0, chr_a[11:10]}];
		case (chr_a[12:11])
			2'b00:   chr_raw = {st.bank_regs[0][7:1], chr_a[10:0]};
			2'b01:   chr_raw = {st.bank_regs[1][7:1], chr_a[10:0]};
			default: chr_raw = {chr_reg, chr_a[9:0]};
		endcase
		chr_addr = {1'b0, chr_raw};
	end

endmodule

// ===== rtl/core/bank_switching_mapper_with_scanline_irq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switching_mapper_with_scanline_irq_core
// Banked PRG/CHR address mapper with scanline IRQ counter and PRG work RAM.
// ----------------------------------------------------------------------------
// Pipeline: input transfer -> s1 (RAM read) -> s2 (output reg) -> output valid.
// Throughput: one item per cycle unless stalled; single RAM port pair handles
//   one access per item, and output stalls back up via a two-entry pipeline.
// Reset: control and bank state clear at once; the work RAM is then zeroed
//   one byte per cycle with in_stall held high.
//   Configuration writes are taken during that sweep.
// ----------------------------------------------------------------------------
module bank_switching_mapper_with_scanline_irq_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input item channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  bsm_pkg::in_item_t                    in_item,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output bsm_pkg::out_item_t                   out_item,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bsm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bsm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// register window in a[14:13] for CPU writes at 0x8000 and up
	localparam logic [1:0] WIN_BANK = 2'd0;
	localparam logic [1:0] WIN_MIRR = 2'd1;
	localparam logic [1:0] WIN_IRQL = 2'd2;
	localparam logic [1:0] WIN_IRQE = 2'd3;

	// ---------------- configuration ----------------
	logic [5:0] prg_units_q;
	logic       alt_nt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q <= 6'd32;
			alt_nt_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsm_pkg::CFG_PRG_UNITS: prg_units_q <= cfg_data[5:0];
				bsm_pkg::CFG_ALT_NT:    alt_nt_q    <= cfg_data[0];
				default:                ;
			endcase
		end
	end

	// ---------------- RAM clearing sweep after reset ----------------
	logic                       clearing_q;
	logic [bsm_pkg::RAM_AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + bsm_pkg::RAM_AW'(1);
			if (clr_idx_q == bsm_pkg::RAM_AW'(bsm_pkg::WORK_RAM_BYTES - 1))
				clearing_q <= 1'b0;
		end
	end

	// ---------------- pipeline handshake ----------------
	// s1: item issued, RAM read data pending; s2: output register
	logic                valid_s1, valid_s2;
	logic                adv_s1;
	logic                accept;
	bsm_pkg::out_item_t  res_s1;
	logic                rd_sel_s1;
	bsm_pkg::out_item_t  res_rd;
	bsm_pkg::out_item_t  out_s2;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !adv_s1);
	assign accept   = in_valid && !in_stall;

	// ---------------- mapper state ----------------
	logic [7:0][7:0] bank_regs_q;
	logic [2:0]      bank_select_q;
	logic            prg_swap_q;
	logic            chr_invert_q;
	logic [1:0]      mirror_q;
	logic [7:0]      irq_latch_q;
	logic [7:0]      irq_count_q;
	logic            irq_off_q;

	// ---------------- item decode ----------------
	logic [2:0]  op;
	logic [15:0] a;
	logic [7:0]  v;
	logic        is_cpu, is_ppu;
	logic        cpu_ram, cpu_reg, ppu_chr;
	logic        ram_rd, ram_wr, reg_wr, a12;
	logic        odd;
	logic [1:0]  mirror_nx;
	logic [7:0]  count_nx;
	logic [18:0] prg_addr, chr_addr;
	bsm_pkg::map_state_t map_st;
	bsm_pkg::out_item_t  res;

	assign op  = in_item.opcode;
	assign a   = in_item.bus_address;
	assign v   = in_item.write_data;
	assign odd = a[0];

	assign is_cpu  = (op == bsm_pkg::OP_CPU_READ) || (op == bsm_pkg::OP_CPU_WRITE);
	assign is_ppu  = (op == bsm_pkg::OP_PPU_READ) || (op == bsm_pkg::OP_PPU_WRITE);
	assign cpu_ram = is_cpu && (a[15:13] == 3'b011);
	assign cpu_reg = is_cpu && a[15];
	assign ppu_chr = is_ppu && (a[15:13] == 3'b000);
	assign ram_rd  = cpu_ram && (op == bsm_pkg::OP_CPU_READ);
	assign ram_wr  = cpu_ram && (op == bsm_pkg::OP_CPU_WRITE);
	assign reg_wr  = cpu_reg && (op == bsm_pkg::OP_CPU_WRITE);
	assign a12     = (op == bsm_pkg::OP_A12_EDGE);

	assign map_st.bank_regs     = bank_regs_q;
	assign map_st.prg_swap_mode = prg_swap_q;
	assign map_st.chr_invert    = chr_invert_q;
	assign map_st.prg_units     = prg_units_q;

	bsm_map u_map (
		.st       (map_st),
		.addr     (a),
		.prg_addr (prg_addr),
		.chr_addr (chr_addr)
	);

	// mirroring and counter values after this item
	always_comb begin
		mirror_nx = mirror_q;
		if (reg_wr && a[14:13] == WIN_MIRR && !odd)
			mirror_nx = alt_nt_q ? bsm_pkg::MIR_FOUR : {1'b0, v[0]};
		count_nx = (irq_count_q == 8'd0) ? irq_latch_q : irq_count_q - 8'd1;
	end

	// result fields known at issue; RAM data joins in s2
	always_comb begin
		res                = '0;
		res.target         = bsm_pkg::TGT_NONE;
		if (cpu_ram) begin
			res.target = bsm_pkg::TGT_RAM;
		end else if (cpu_reg && op == bsm_pkg::OP_CPU_READ) begin
			res.target         = bsm_pkg::TGT_PRG;
			res.mapped_address = prg_addr;
		end else if (ppu_chr) begin
			res.target         = bsm_pkg::TGT_CHR;
			res.mapped_address = chr_addr;
			res.external_write = (op == bsm_pkg::OP_PPU_WRITE);
		end
		res.irq_pulse = a12 && (count_nx == 8'd0) && !irq_off_q;
		res.mirroring = alt_nt_q ? bsm_pkg::MIR_FOUR : mirror_nx;
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_regs_q   <= '0;
			bank_select_q <= 3'd0;
			prg_swap_q    <= 1'b0;
			chr_invert_q  <= 1'b0;
			mirror_q      <= bsm_pkg::MIR_VERTICAL;
			irq_latch_q   <= 8'd0;
			irq_count_q   <= 8'd0;
			irq_off_q     <= 1'b0;
		end else if (accept) begin
			mirror_q <= mirror_nx;
			if (a12)
				irq_count_q <= count_nx;
			if (reg_wr) begin
				case (a[14:13])
					WIN_BANK: begin
						if (!odd) begin
							bank_select_q <= v[2:0];
							prg_swap_q    <= v[6];
							chr_invert_q  <= v[7];
						end else begin
							bank_regs_q[bank_select_q] <= v;
						end
					end
					WIN_IRQL: begin
						if (!odd)
							irq_latch_q <= v;
						else
							irq_count_q <= 8'd0;
					end
					WIN_IRQE: irq_off_q <= !odd;
					default:  ; // mirroring handled above, RAM protect ignored
				endcase
			end
		end
	end

	// ---------------- work RAM ----------------
	// Each item reads or writes at its own transfer edge, so a read always
	// sees every earlier write; no forwarding path is needed.
	logic                       ram_we;
	logic [bsm_pkg::RAM_AW-1:0] ram_waddr, ram_idx;
	logic [7:0]                 ram_wdata, ram_rdata;

	assign ram_idx   = bsm_pkg::ram_index(a);
	assign ram_we    = clearing_q || (accept && ram_wr);
	assign ram_waddr = clearing_q ? clr_idx_q : ram_idx;
	assign ram_wdata = clearing_q ? 8'h00 : v;

	bsm_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && ram_rd),
		.raddr (ram_idx),
		.rdata (ram_rdata)
	);

	// ---------------- pipeline registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	// s1 result with the RAM byte merged in
	always_comb begin
		res_rd           = res_s1;
		res_rd.read_data = rd_sel_s1 ? ram_rdata : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res;
			rd_sel_s1 <= ram_rd;
		end
		if (adv_s1)
			out_s2 <= res_rd;
	end

	assign out_valid = valid_s2;
	assign out_item  = out_s2;

endmodule
